// ----- rtl/prl_pkg.sv -----
package prl_pkg;

   // Defaults for the top-level parameters
   localparam int SAMPLE_WIDTH   = 16;
   localparam int COEF_FRAC_BITS = 16;

   // Kernel shape register, a in Q0.16, about 0.3 after reset
   localparam int              KERNEL_A_W     = 16;
   localparam logic [15:0]     KERNEL_A_RESET = 16'd19661;

   // Five-tap kernel, one cell per tap
   localparam int TAPS = 5;

   // Result queue depth
   localparam int FIFO_DEPTH = 8;

   // Coefficient width: holds 2^F, 4a (a < 2^16) and 2^F - 2a, all signed
   function automatic int coef_width(input int frac_bits);
      int w;
      w = frac_bits + 2;
      if (w < 19) begin
         w = 19;
      end
      return w;
   endfunction

   typedef enum logic [1:0] {
      FEED,
      FLUSH_A,
      FLUSH_B
   } feed_type;

   // Control travelling with a window of taps through the pipeline
   typedef struct packed {
      logic push;    // window yields a filtered value that enters pairing
      logic flush;   // window belongs to the trailing zero padding
      logic close;   // last window of its line, pairing restarts after it
   } tok_type;

endpackage

// ----- rtl/pyramid_reduce_line_core.sv -----
// Channel   Direction  Handshake              Payload
// req_      in         req_valid / req_ready  req_sample, req_line_end
// rsp_      out        rsp_valid / rsp_ready  rsp_level_sample, rsp_level_last
// csr_      in         csr_we (no wait)       csr_wdata (kernel_a, Q0.16)
//
// One sample beat a cycle while req_ready is high. After a line's end beat,
// req_ready stays low while FLUSH_A and FLUSH_B shift zero padding into the
// five-cell tap row. A pair's closing window has its products registered in
// the cells and summed in the pair stage before the result enters the queue.
// Reset is synchronous and needs no clearing pass. Outside the flush, req_ready
// falls only when the result queue plus the beats still in the pipeline would
// fill its eight entries; a stalled rsp_ side never loses or repeats a result.
module pyramid_reduce_line_core #(
   parameter int SAMPLE_WIDTH   = prl_pkg::SAMPLE_WIDTH,
   parameter int COEF_FRAC_BITS = prl_pkg::COEF_FRAC_BITS
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic signed [SAMPLE_WIDTH-1:0] req_sample,
   input  logic                           req_line_end,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic signed [SAMPLE_WIDTH-1:0] rsp_level_sample,
   output logic                           rsp_level_last,
   input  logic                           csr_we,
   input  logic [prl_pkg::KERNEL_A_W-1:0] csr_wdata
);

   localparam int COEF_W = prl_pkg::coef_width(COEF_FRAC_BITS);
   localparam int PROD_W = SAMPLE_WIDTH + COEF_W;
   localparam int CNT_W  = $clog2(prl_pkg::FIFO_DEPTH + 1);
   localparam logic [1:0] LINE_FULL = 2'd2;   // two taps of this line seen
   localparam logic signed [COEF_W-1:0] COEF_ONE = COEF_W'(1) << COEF_FRAC_BITS;

   // ---- kernel register and tap weights ----
   logic [prl_pkg::KERNEL_A_W-1:0] kernel_a_ff, kernel_a_in;
   logic signed [COEF_W-1:0] coef [prl_pkg::TAPS];
   logic signed [COEF_W-1:0] coef_outer, coef_center;

   assign kernel_a_in = csr_we ? csr_wdata : kernel_a_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         kernel_a_ff <= prl_pkg::KERNEL_A_RESET;
      end else begin
         kernel_a_ff <= kernel_a_in;
      end
   end

   // outer taps (1-2a)/4, inner 1/4, centre a, all scaled by 4*2^F
   assign coef_outer  = COEF_ONE - COEF_W'({1'b0, kernel_a_ff, 1'b0});
   assign coef_center = COEF_W'({1'b0, kernel_a_ff, 2'b00});
   assign coef[0] = coef_outer;
   assign coef[1] = COEF_ONE;
   assign coef[2] = coef_center;
   assign coef[3] = COEF_ONE;
   assign coef[4] = coef_outer;

   // ---- feed control ----
   // End beat enters, then two zero taps flush the trailing padding.
   // The zeros also become the leading padding of the next line, so the
   // cell row never needs clearing: a window that counts carries at most
   // two taps from before its line, and those are the flush zeros.
   prl_pkg::feed_type feed_ff, feed_in;
   logic [1:0]        cnt_ff, cnt_in;
   prl_pkg::tok_type  tok, s0_ff, s0_in, s1_ff;
   logic              shift;
   logic              room;
   logic signed [SAMPLE_WIDTH-1:0] chain_in;
   logic [CNT_W-1:0]  fifo_count;
   logic              pair_busy;
   logic [CNT_W:0]    occupancy;

   // every beat in flight may still write one result
   assign occupancy = {1'b0, fifo_count} + (CNT_W+1)'(s0_ff.push)
                    + (CNT_W+1)'(s1_ff.push) + (CNT_W+1)'(pair_busy);
   assign room = (occupancy < (CNT_W+1)'(prl_pkg::FIFO_DEPTH));

   always_comb begin
      feed_in   = feed_ff;
      shift     = 1'b0;
      chain_in  = '0;
      req_ready = 1'b0;
      tok.push  = (cnt_ff == LINE_FULL);
      tok.flush = 1'b1;
      tok.close = 1'b0;
      case (feed_ff)
         prl_pkg::FEED: begin
            req_ready = room;
            tok.flush = 1'b0;
            chain_in  = req_sample;
            if (req_valid && room) begin
               shift = 1'b1;
               if (req_line_end) begin
                  feed_in = prl_pkg::FLUSH_A;
               end
            end
         end
         prl_pkg::FLUSH_A: begin
            if (room) begin
               shift   = 1'b1;
               feed_in = prl_pkg::FLUSH_B;
            end
         end
         prl_pkg::FLUSH_B: begin
            tok.close = 1'b1;
            if (room) begin
               shift   = 1'b1;
               feed_in = prl_pkg::FEED;
            end
         end
         default: begin
            feed_in = prl_pkg::FEED;
         end
      endcase
   end

   always_comb begin
      cnt_in = cnt_ff;
      if (shift) begin
         if (feed_ff == prl_pkg::FLUSH_B) begin
            cnt_in = '0;
         end else if (cnt_ff != LINE_FULL) begin
            cnt_in = cnt_ff + 1'b1;
         end
      end
   end

   assign s0_in = shift ? tok : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         feed_ff <= prl_pkg::FEED;
         cnt_ff  <= '0;
         s0_ff   <= '0;
         s1_ff   <= '0;
      end else begin
         feed_ff <= feed_in;
         cnt_ff  <= cnt_in;
         s0_ff   <= s0_in;    // window now in the taps
         s1_ff   <= s0_ff;    // its products now in the cells
      end
   end

   // ---- tap row: cell 0 takes the newest tap ----
   logic signed [SAMPLE_WIDTH-1:0] tap  [prl_pkg::TAPS];
   logic signed [PROD_W-1:0]       prod [prl_pkg::TAPS];

   for (genvar k = 0; k < prl_pkg::TAPS; k++) begin : g_cell
      logic signed [SAMPLE_WIDTH-1:0] tap_prev;
      if (k == 0) begin : g_head
         assign tap_prev = chain_in;
      end else begin : g_link
         assign tap_prev = tap[k-1];
      end
      prl_tap_cell #(
         .SAMPLE_WIDTH  (SAMPLE_WIDTH),
         .COEF_FRAC_BITS(COEF_FRAC_BITS)
      ) u_cell (
         .clock   (clock),
         .reset   (reset),
         .shift   (shift),
         .tap_prev(tap_prev),
         .coef    (coef[k]),
         .tap_out (tap[k]),
         .prod_out(prod[k])
      );
   end

   // ---- sum, pairing, rounding and saturation ----
   logic                           wr_en;
   logic signed [SAMPLE_WIDTH-1:0] wr_sample;
   logic                           wr_last;

   prl_pair #(
      .SAMPLE_WIDTH  (SAMPLE_WIDTH),
      .COEF_FRAC_BITS(COEF_FRAC_BITS)
   ) u_pair (
      .clock    (clock),
      .reset    (reset),
      .tok      (s1_ff),
      .prod     (prod),
      .busy     (pair_busy),
      .wr_en    (wr_en),
      .wr_sample(wr_sample),
      .wr_last  (wr_last)
   );

   // ---- result queue ----
   prl_fifo #(
      .SAMPLE_WIDTH(SAMPLE_WIDTH)
   ) u_fifo (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (wr_en),
      .wr_sample(wr_sample),
      .wr_last  (wr_last),
      .rd_en    (rsp_valid & rsp_ready),
      .rd_valid (rsp_valid),
      .rd_sample(rsp_level_sample),
      .rd_last  (rsp_level_last),
      .count    (fifo_count)
   );

endmodule

// ----- rtl/prl_tap_cell.sv -----
module prl_tap_cell #(
   parameter  int SAMPLE_WIDTH   = prl_pkg::SAMPLE_WIDTH,
   parameter  int COEF_FRAC_BITS = prl_pkg::COEF_FRAC_BITS,
   localparam int COEF_W         = prl_pkg::coef_width(COEF_FRAC_BITS),
   localparam int PROD_W         = SAMPLE_WIDTH + COEF_W
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     shift,
   input  logic signed [SAMPLE_WIDTH-1:0] tap_prev,
   input  logic signed [COEF_W-1:0]       coef,
   output logic signed [SAMPLE_WIDTH-1:0] tap_out,
   output logic signed [PROD_W-1:0]       prod_out
);

   logic signed [SAMPLE_WIDTH-1:0] tap_ff;
   logic signed [SAMPLE_WIDTH-1:0] tap_in;
   logic signed [PROD_W-1:0]       prod_ff;
   logic signed [PROD_W-1:0]       prod_in;

   assign tap_in  = shift ? tap_prev : tap_ff;
   // weight of the window held during this cycle
   assign prod_in = tap_ff * coef;

   always_ff @(posedge clock) begin
      if (reset) begin
         tap_ff <= '0;
      end else begin
         tap_ff <= tap_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign tap_out  = tap_ff;
   assign prod_out = prod_ff;

endmodule

// ----- rtl/prl_pair.sv -----
module prl_pair #(
   parameter  int SAMPLE_WIDTH   = prl_pkg::SAMPLE_WIDTH,
   parameter  int COEF_FRAC_BITS = prl_pkg::COEF_FRAC_BITS,
   localparam int COEF_W         = prl_pkg::coef_width(COEF_FRAC_BITS),
   localparam int PROD_W         = SAMPLE_WIDTH + COEF_W
) (
   input  logic                       clock,
   input  logic                       reset,
   input  prl_pkg::tok_type           tok,
   input  logic signed [PROD_W-1:0]   prod [prl_pkg::TAPS],
   output logic                       busy,
   output logic                       wr_en,
   output logic signed [SAMPLE_WIDTH-1:0] wr_sample,
   output logic                       wr_last
);

   localparam int SUM_W = PROD_W + 3;
   localparam int ACC_W = SUM_W + 1;
   localparam logic signed [ACC_W-1:0] ROUND = ACC_W'(1) << (COEF_FRAC_BITS + 2);
   localparam logic signed [ACC_W-1:0] SAT_HI =
      {{(ACC_W-SAMPLE_WIDTH+1){1'b0}}, {(SAMPLE_WIDTH-1){1'b1}}};
   localparam logic signed [ACC_W-1:0] SAT_LO =
      {{(ACC_W-SAMPLE_WIDTH+1){1'b1}}, {(SAMPLE_WIDTH-1){1'b0}}};

   logic signed [SUM_W-1:0] sum_ff;
   logic signed [SUM_W-1:0] sum_in;
   logic signed [SUM_W-1:0] held_ff;
   logic signed [SUM_W-1:0] held_in;
   prl_pkg::tok_type        tok_ff;
   logic                    phase_ff;
   logic                    phase_in;
   logic signed [ACC_W-1:0] acc;
   logic signed [ACC_W-1:0] avg;
   logic signed [ACC_W-1:0] sat;

   always_comb begin
      sum_in = '0;
      for (int k = 0; k < prl_pkg::TAPS; k++) begin
         sum_in = sum_in + SUM_W'(prod[k]);
      end
   end

   // pair average, floor after adding half
   assign acc = ACC_W'(held_ff) + ACC_W'(sum_ff) + ROUND;
   assign avg = acc >>> (COEF_FRAC_BITS + 3);

   always_comb begin
      sat = avg;
      if (avg > SAT_HI) begin
         sat = SAT_HI;
      end else if (avg < SAT_LO) begin
         sat = SAT_LO;
      end
   end

   // an unpartnered value at the end of an odd line is dropped
   assign phase_in = tok_ff.close ? 1'b0 : (tok_ff.push ? ~phase_ff : phase_ff);
   assign held_in  = (tok_ff.push && !phase_ff) ? sum_ff : held_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff   <= '0;
         phase_ff <= 1'b0;
      end else begin
         tok_ff   <= tok;
         phase_ff <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      sum_ff  <= sum_in;
      held_ff <= held_in;
   end

   assign busy      = tok_ff.push;
   assign wr_en     = tok_ff.push & phase_ff;
   assign wr_sample = sat[SAMPLE_WIDTH-1:0];
   // a pair closed by the padding is always the line's final result
   assign wr_last   = tok_ff.flush;

endmodule

// ----- rtl/prl_fifo.sv -----
module prl_fifo #(
   parameter  int SAMPLE_WIDTH = prl_pkg::SAMPLE_WIDTH,
   localparam int CNT_W        = $clog2(prl_pkg::FIFO_DEPTH + 1)
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           wr_en,
   input  logic signed [SAMPLE_WIDTH-1:0] wr_sample,
   input  logic                           wr_last,
   input  logic                           rd_en,
   output logic                           rd_valid,
   output logic signed [SAMPLE_WIDTH-1:0] rd_sample,
   output logic                           rd_last,
   output logic [CNT_W-1:0]               count
);

   localparam int DEPTH = prl_pkg::FIFO_DEPTH;
   localparam int PTR_W = $clog2(DEPTH);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

   logic signed [SAMPLE_WIDTH-1:0] sample_ff [DEPTH];
   logic                           last_ff   [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff,  count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (wr_en) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (rd_en) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      count_in = count_ff + CNT_W'(wr_en) - CNT_W'(rd_en);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         sample_ff[wr_ptr_ff] <= wr_sample;
         last_ff[wr_ptr_ff]   <= wr_last;
      end
   end

   assign rd_valid  = (count_ff != '0);
   assign rd_sample = sample_ff[rd_ptr_ff];
   assign rd_last   = last_ff[rd_ptr_ff];
   assign count     = count_ff;

endmodule

// ----- rtl/prl_checker.sv -----
module prl_checker #(
   parameter int SAMPLE_WIDTH = prl_pkg::SAMPLE_WIDTH
) (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_valid,
   input logic                           req_ready,
   input logic                           req_line_end,
   input logic                           rsp_valid,
   input logic                           rsp_ready,
   input logic signed [SAMPLE_WIDTH-1:0] rsp_level_sample,
   input logic                           rsp_level_last
);

   // a waiting result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=>
         rsp_valid && $stable(rsp_level_sample) && $stable(rsp_level_last))
      else $error("result beat changed while stalled");

   // req_ready stays low through the padding steps that follow every line end
   a_flush_gap: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_line_end |=> !req_ready ##1 !req_ready)
      else $error("sample taken during line-end flush");

   // queue empties on reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result present after reset");

   // the tap, product and sum registers lie before the queue, so no result can appear right after reset
   a_reset_latency: assert property (@(posedge clock)
      reset |=> !rsp_valid ##1 !rsp_valid)
      else $error("result appeared too early after reset");

endmodule

bind pyramid_reduce_line_core prl_checker #(
   .SAMPLE_WIDTH(SAMPLE_WIDTH)
) u_prl_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_ready       (req_ready),
   .req_line_end    (req_line_end),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_level_sample(rsp_level_sample),
   .rsp_level_last  (rsp_level_last)
);
